/* src/range_owner_lookup_defines.svh */
// Assertion macros used by the rol_checker file.
`ifndef RANGE_OWNER_LOOKUP_DEFINES_SVH
`define RANGE_OWNER_LOOKUP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ROL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("range owner lookup check failed");

// Consequent must hold in the cycle after the antecedent.
`define ROL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("range owner lookup check failed");

`endif

/* src/rol_pkg.sv */
// ----------------------------------------------------------------------------
// rol_pkg
// Types and constants shared by the range owner lookup modules.
// ----------------------------------------------------------------------------
package rol_pkg;

  localparam int MaxRanges = 64;
  localparam int CntW      = $clog2(MaxRanges + 1);
  localparam int IdW       = 31;
  localparam int OwnW      = 16;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [IdW-1:0]  range_low;
    logic [IdW-1:0]  range_high;
    logic [OwnW-1:0] range_owner;
    logic [IdW-1:0]  lookup_id;
  } in_t;

  typedef struct packed {
    logic [OwnW-1:0] owner;
    logic            from_table;
    logic            status;
  } out_t;

  typedef struct packed {
    logic [IdW-1:0]  low;
    logic [IdW-1:0]  high;
    logic [OwnW-1:0] owner;
  } entry_t;

  // per-cell control from the top level
  typedef struct packed {
    logic occ;     // cell holds a live entry
    logic at_end;  // cell is the first free slot
    logic first;   // leftmost cell of the chain
    logic add_en;  // an add transfer is accepted this cycle
  } cell_ctl_t;

  // registered lookup flags of one cell
  typedef struct packed {
    logic le;      // live and low not above the id
    logic hi_ok;   // id not above high
  } cell_flag_t;

endpackage

/* src/rol_cell.sv */
// ----------------------------------------------------------------------------
// rol_cell
// One table slot: holds an entry, shifts right on a sorted insert, and flags
// its relation to the lookup id.
// ----------------------------------------------------------------------------
module rol_cell (
  input  logic                   clk_i,
  input  rol_pkg::cell_ctl_t     ctl_i,
  input  rol_pkg::entry_t        new_i,
  input  rol_pkg::entry_t        left_i,
  input  logic                   left_gt_i,
  input  logic [rol_pkg::IdW-1:0] id_i,
  output rol_pkg::entry_t        entry_o,
  output logic                   gt_o,
  output rol_pkg::cell_flag_t    flag_o
);
  import rol_pkg::*;

  entry_t     entry_q, entry_d;
  cell_flag_t flag_q;

  // live entry sorts after the one being added
  assign gt_o = ctl_i.occ && (entry_q.low > new_i.low);

  // insert: take the left neighbor, take the new entry, or keep
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.add_en) begin
      if (!ctl_i.first && left_gt_i) begin
        entry_d = left_i;
      end else if (gt_o || ctl_i.at_end) begin
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q      <= entry_d;
    flag_q.le    <= ctl_i.occ && (entry_q.low <= id_i);
    flag_q.hi_ok <= (id_i <= entry_q.high);
  end

  assign entry_o = entry_q;
  assign flag_o  = flag_q;

endmodule

/* src/rol_div.sv */
// ----------------------------------------------------------------------------
// rol_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rol_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [rol_pkg::IdW-1:0]  dividend_i,
  input  logic [rol_pkg::OwnW-1:0] divisor_i,
  output logic                    done_o,
  output logic [rol_pkg::OwnW-1:0] rem_o
);
  import rol_pkg::*;

  localparam int StepW = $clog2(IdW);

  logic             busy_q, done_q;
  logic [StepW-1:0] step_q;
  logic [IdW-1:0]   num_q;
  logic [OwnW:0]    rem_q, trial;

  // shift in the next dividend bit and subtract when it fits
  assign trial = {rem_q[OwnW-1:0], num_q[IdW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(IdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[IdW-2:0], 1'b0};
      rem_q <= (trial >= {1'b0, divisor_i}) ? trial - {1'b0, divisor_i} : trial;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[OwnW-1:0];

endmodule

/* src/range_owner_lookup.sv */
// ----------------------------------------------------------------------------
// range_owner_lookup
// Sorted id range table that maps an id to an owner, with modulo fallback.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one command per
//   transfer: clear, add range, or look up id. Output channel out_valid_o /
//   out_stall_i / out_data_o returns exactly one result per command.
//   proc_count is written on cfg_valid_i / cfg_ready_o / cfg_data_i, ready
//   always high; the user writes it only while the block is idle, unchecked.
// Sequencing:
//   Clear and add pass from the idle state to the pending state and then into
//   the output register. A lookup waits in the lookup state while the bit-serial
//   remainder unit walks the 31 id bits, then moves its result through the
//   pending state into the output register; the table cells settle their
//   flags in parallel. One command is in work at a time.
// Reset:
//   The table is empty, proc_count is 1, and no result is pending.
// Stall:
//   A result waits in the output register while out_stall_i is high; one more
//   command may finish behind it, after which in_stall_o stays high.
// ----------------------------------------------------------------------------
module range_owner_lookup (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  rol_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output rol_pkg::out_t            out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [rol_pkg::OwnW-1:0] cfg_data_i
);
  import rol_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_PEND} state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [OwnW-1:0] proc_q;
  logic [IdW-1:0]  id_q;
  out_t            res_q, out_q;
  logic            out_valid_q;

  logic            in_acc, add_acc, full, div_done;
  logic [OwnW-1:0] rem;
  entry_t          new_entry;
  entry_t          entry  [MaxRanges];
  logic            gt     [MaxRanges];
  cell_flag_t      flag   [MaxRanges];
  cell_ctl_t       ctl    [MaxRanges];

  assign in_acc    = in_valid_i && !in_stall_o;
  assign full      = (count_q >= CntW'(MaxRanges));
  assign add_acc   = in_acc && (in_data_i.cmd == CMD_ADD) && !full;
  assign new_entry = '{low: in_data_i.range_low, high: in_data_i.range_high,
                       owner: in_data_i.range_owner};

  // chain of table cells
  for (genvar i = 0; i < MaxRanges; i++) begin : g_cell
    assign ctl[i].occ    = (CntW'(i) < count_q);
    assign ctl[i].at_end = (CntW'(i) == count_q);
    assign ctl[i].first  = (i == 0);
    assign ctl[i].add_en = add_acc;
    rol_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl[i]),
      .new_i     (new_entry),
      .left_i    ((i == 0) ? new_entry : entry[(i == 0) ? 0 : i - 1]),
      .left_gt_i ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .id_i      (id_q),
      .entry_o   (entry[i]),
      .gt_o      (gt[i]),
      .flag_o    (flag[i])
    );
  end

  rol_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && (in_data_i.cmd == CMD_LOOKUP)),
    .dividend_i (in_data_i.lookup_id),
    .divisor_i  (proc_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  // pick the last entry with low not above the id
  logic            sel_hok, last_hok, hit;
  logic [OwnW-1:0] sel_own;
  out_t            look_res;
  always_comb begin
    sel_hok  = 1'b0;
    last_hok = 1'b0;
    sel_own  = '0;
    for (int i = 0; i < MaxRanges; i++) begin
      if (flag[i].le && ((i == MaxRanges - 1) || !flag[(i + 1) % MaxRanges].le)) begin
        sel_hok = sel_hok | flag[i].hi_ok;
        sel_own = sel_own | entry[i].owner;
      end
      if (CntW'(i + 1) == count_q) begin
        last_hok = last_hok | flag[i].hi_ok;
      end
    end
    hit                 = flag[0].le && sel_hok && last_hok;
    look_res.status     = 1'b0;
    look_res.from_table = hit;
    if (hit) begin
      look_res.owner = (sel_own < OwnW'(count_q)) ? sel_own : '0;
    end else begin
      look_res.owner = (proc_q == '0) ? '0 : rem;
    end
  end

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_q <= OwnW'(1);
    end else if (cfg_valid_i) begin
      proc_q <= cfg_data_i;
    end
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_acc && (in_data_i.cmd == CMD_CLEAR)) begin
      count_q <= '0;
    end else if (add_acc) begin
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q <= in_data_i.lookup_id;
    end
  end

  // command sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      // the pending state reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_PEND)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data_i.cmd == CMD_LOOKUP) begin
              state_q <= ST_LOOK;
            end else begin
              res_q   <= '{owner: '0, from_table: 1'b0,
                           status: (in_data_i.cmd == CMD_ADD) && full};
              state_q <= ST_PEND;
            end
          end
        end
        ST_LOOK: begin
          if (div_done) begin
            res_q   <= look_res;
            state_q <= ST_PEND;
          end
        end
        ST_PEND: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/rol_checker.sv */
// ----------------------------------------------------------------------------
// rol_checker
// Port-level checks of the range owner lookup, bound to the top level.
// ----------------------------------------------------------------------------
`include "range_owner_lookup_defines.svh"

module rol_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rol_pkg::out_t out_data_o
);
  import rol_pkg::*;

  // a stalled result holds
  `ROL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  // a dropped add never reports a table owner
  `ROL_ASSERT_NOW(a_full_clean, out_valid_o && out_data_o.status,
                  !out_data_o.from_table && (out_data_o.owner == '0))
  // an accepted command blocks the input on the next cycle
  `ROL_ASSERT_NEXT(a_one_cmd, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind range_owner_lookup rol_checker u_rol_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* verif/range_owner_lookup_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_owner_lookup_checker
// Watches the command, result and proc_count channels of the range owner
// lookup. It keeps its own copy of the range table and the divisor, works out
// the owner each command should return, and compares the results in order.
// ----------------------------------------------------------------------------
module range_owner_lookup_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  rol_pkg::in_t             in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  rol_pkg::out_t            out_data_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [rol_pkg::OwnW-1:0] cfg_data_i,
  output int                       pending_o,
  output int                       errors_o
);
  import rol_pkg::*;

  // shadow copy of the table and the divisor
  entry_t          table_q [MaxRanges];
  int unsigned     count_q;
  logic [OwnW-1:0] divisor_q;
  out_t            owner_fifo [$];

  function automatic logic [OwnW-1:0] modulo_owner(logic [IdW-1:0] id);
    if (divisor_q == '0) return '0;
    return OwnW'(id % divisor_q);
  endfunction

  // apply one command to the shadow table and return its result
  function automatic out_t apply_command(in_t c);
    out_t r;
    int   pos;
    r = '0;
    case (c.cmd)
      CMD_CLEAR: count_q = 0;
      CMD_ADD: begin
        if (count_q >= MaxRanges) begin
          r.status = 1'b1;
        end else begin
          pos = count_q;
          while (pos > 0 && table_q[pos-1].low > c.range_low) begin
            table_q[pos] = table_q[pos-1];
            pos--;
          end
          table_q[pos] = '{c.range_low, c.range_high, c.range_owner};
          count_q++;
        end
      end
      CMD_LOOKUP: begin
        pos = count_q;
        while (pos > 0 && table_q[pos-1].low > c.lookup_id) pos--;
        if (count_q == 0 || c.lookup_id < table_q[0].low ||
            c.lookup_id > table_q[count_q-1].high || pos == 0 ||
            c.lookup_id > table_q[pos-1].high) begin
          r.owner = modulo_owner(c.lookup_id);
        end else begin
          r.from_table = 1'b1;
          r.owner = (table_q[pos-1].owner < count_q) ? table_q[pos-1].owner : '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_o = owner_fifo.size();

  // predict on command transfers, compare on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      count_q   = 0;
      divisor_q = 16'd1;
      owner_fifo.delete();
      errors_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) divisor_q = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (owner_fifo.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_i);
          errors_o++;
        end else begin
          exp_r = owner_fifo.pop_front();
          if (out_data_i.owner !== exp_r.owner) begin
            $display("%0t: owner expected %0d actual %0d", $time, exp_r.owner,
                     out_data_i.owner);
            errors_o++;
          end
          if (out_data_i.from_table !== exp_r.from_table) begin
            $display("%0t: from_table expected %0b actual %0b", $time,
                     exp_r.from_table, out_data_i.from_table);
            errors_o++;
          end
          if (out_data_i.status !== exp_r.status) begin
            $display("%0t: status expected %0b actual %0b", $time, exp_r.status,
                     out_data_i.status);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) owner_fifo.push_back(apply_command(in_data_i));
    end
  end
endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives clear, add, lookup and no-op commands with random gaps and output stalls
// through several proc_count settings; a checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import rol_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  in_t             in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_t            out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [OwnW-1:0] cfg_data_i = '0;
  int              pending;
  int              errors;
  logic [IdW-1:0]  base_q [$];

  always #5 clk_i = ~clk_i;

  range_owner_lookup u_dut (.*);

  range_owner_lookup_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // random output stalls, with quiet stretches
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(9) == 0) begin
        n = gap_len();
        if (n != 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end else if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(200, 50)) @(negedge clk_i);
      end
    end
  end

  // one command transfer, with a random gap before it
  task automatic send_cmd(logic [1:0] c, logic [IdW-1:0] lo, logic [IdW-1:0] hi,
                          logic [OwnW-1:0] ow, logic [IdW-1:0] id);
    int n;
    logic [127:0] fill;
    n = gap_len();
    repeat (n + 1) @(negedge clk_i);
    in_data_i  <= '{c, lo, hi, ow, id};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    fill = {$urandom, $urandom, $urandom, $urandom};
    in_valid_i <= 1'b0;
    in_data_i  <= fill[$bits(in_t)-1:0];
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_divisor(logic [OwnW-1:0] d);
    drain();
    cfg_data_i  <= d;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic lookup(logic [IdW-1:0] id);
    send_cmd(CMD_LOOKUP, IdW'($urandom), IdW'($urandom), OwnW'($urandom), id);
  endtask

  // build a table of disjoint ranges, then probe inside, edges, gaps and random ids, with stray add and no-op commands
  task automatic table_phase(int entries, int probes);
    logic [IdW-1:0] lo, span;
    int k;
    base_q.delete();
    send_cmd(CMD_CLEAR, IdW'($urandom), IdW'($urandom), OwnW'($urandom), IdW'($urandom));
    span = IdW'($urandom_range(1, 1) << $urandom_range(24, 2));
    for (int i = 0; i < entries; i++) begin
      lo = IdW'(i) * (span * 2) + IdW'($urandom_range(3));
      base_q.push_back(lo);
    end
    base_q.shuffle();
    foreach (base_q[i])
      send_cmd(CMD_ADD, base_q[i], base_q[i] + span - 1'b1,
               ($urandom_range(1)) ? OwnW'($urandom_range(entries + 2)) : OwnW'($urandom),
               IdW'($urandom));
    for (int i = 0; i < probes; i++) begin
      if ($urandom_range(9) == 0) begin
        send_cmd(($urandom_range(1)) ? CMD_ADD : CMD_NOP, IdW'($urandom), IdW'($urandom),
                 OwnW'($urandom), IdW'($urandom));
      end else begin
        k = $urandom_range(base_q.size() - 1);
        case ($urandom_range(5))
          0: lookup(base_q[k]);
          1: lookup(base_q[k] + span - 1'b1);
          2: lookup(base_q[k] + span);
          3: lookup(base_q[k] - 1'b1);
          4: lookup(IdW'($urandom));
          default: lookup(base_q[k] + IdW'($urandom_range(span - 1)));
        endcase
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: empty table, extremes, full table, odd commands
    lookup('0);
    lookup({IdW{1'b1}});
    send_cmd(CMD_NOP, {IdW{1'b1}}, {IdW{1'b1}}, '1, {IdW{1'b1}});
    send_cmd(CMD_ADD, 31'd100, 31'd199, 16'd0, '0);
    send_cmd(CMD_ADD, 31'd100, 31'd149, 16'd1, '0);
    send_cmd(CMD_ADD, 31'd50, 31'd40, 16'hFFFF, '0);
    send_cmd(CMD_ADD, {IdW{1'b1}}, {IdW{1'b1}}, 16'd2, '0);
    lookup(31'd99);
    lookup(31'd100);
    lookup(31'd160);
    lookup(31'd45);
    lookup({IdW{1'b1}});
    write_divisor('0);
    lookup(31'd12345);
    write_divisor(16'hFFFF);
    lookup({IdW{1'b1}});
    for (int i = 0; i < MaxRanges + 2; i++)
      send_cmd(CMD_ADD, IdW'(i * 10 + 1000), IdW'(i * 10 + 1005), OwnW'(i), '0);
    lookup(31'd1003);
    lookup(31'd1007);
    send_cmd(CMD_CLEAR, '1, '1, '1, '1);
    lookup(31'd1003);

    // random phases over several divisors
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: write_divisor(16'd1);
        1: write_divisor(OwnW'($urandom_range(2, 17)));
        2: write_divisor(OwnW'($urandom));
        default: write_divisor((ph % 8 == 3) ? 16'hFFFF : 16'd0);
      endcase
      table_phase((ph % 5 == 0) ? MaxRanges : $urandom_range(12, 1), 45);
    end

    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #30ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/rol_pkg.sv
src/rol_cell.sv
src/rol_div.sv
src/range_owner_lookup.sv
src/rol_checker.sv
verif/range_owner_lookup_checker.sv
verif/tb.sv
